FILE: sv/tcgw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_pkg: shared definitions of the text console glyph writer
// Font geometry, character codes, configuration indexes and the command word
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tcgw_pkg;

  // Font geometry
  localparam int GLYPH_ROWS    = 16;
  localparam int GLYPH_COLUMNS = 8;
  localparam int GLYPH_COUNT   = 256;
  localparam int ROW_W         = $clog2(GLYPH_ROWS);
  localparam int FONT_DEPTH    = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);

  // Field and state widths
  localparam int CODE_W    = 8;
  localparam int GROW_W    = 4;
  localparam int BITS_W    = 8;
  localparam int COL_W     = 12;
  localparam int ROWPOS_W  = 13;
  localparam int DIM_W     = 13;
  localparam int COLOR_W   = 32;
  localparam int OFF_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int MAX_WIDTH  = 4096;
  localparam int TAB_SPACES = 4;
  localparam int TAB_W      = $clog2(TAB_SPACES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // Request types
  localparam logic REQ_PRINT = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // Character codes with a meaning of their own
  localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [DIM_W-1:0]   line_pitch;
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_GLYPH,
    CMD_EMPTY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [CODE_W-1:0]   code;
    logic [GROW_W-1:0]   grow;
    logic [BITS_W-1:0]   bits;
    logic [ROWPOS_W-1:0] cur_row;
    logic [COL_W-1:0]    cur_col;
    logic                clear;
    logic                last;
  } cmd_t;

endpackage

FILE: sv/tcgw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// while no read is enabled.
// ----------------------------------------------------------------------------
module tcgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tcgw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_front: request decoder and cursor keeper
// Classifies each accepted word, advances the cursor with wrap and overflow
// checks, and pushes load, glyph and empty commands into the queue.
// ----------------------------------------------------------------------------
module tcgw_front import tcgw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  logic [GROW_W-1:0] glyph_row_i,
  input  logic [BITS_W-1:0] glyph_bits_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [ROWPOS_W-1:0] row;
    logic                ovf;
  } settle_t;

  // Line wrap followed by the bottom-of-screen check.
  function automatic settle_t settle(input logic [COL_W:0]    col,
                                     input logic [ROWPOS_W-1:0] row,
                                     input logic [DIM_W-1:0]    sw,
                                     input logic [DIM_W-1:0]    sh);
    settle_t             res;
    logic [DIM_W-1:0]    effw;
    logic [COL_W:0]      c;
    logic [ROWPOS_W-1:0] r;
    effw = (sw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : sw;
    c    = col;
    r    = row;
    if (({1'b0, c} + (COL_W+2)'(GLYPH_COLUMNS)) > (COL_W+2)'(effw)) begin
      c = '0;
      r = r + ROWPOS_W'(GLYPH_ROWS);
    end
    res.ovf = ({1'b0, r} + (ROWPOS_W+1)'(GLYPH_ROWS)) > {1'b0, sh};
    if (res.ovf) begin
      c = '0;
      r = '0;
    end
    res.col = c[COL_W-1:0];
    res.row = r;
    return res;
  endfunction

  logic [COL_W-1:0]    col_q, col_d;
  logic [ROWPOS_W-1:0] row_q, row_d;
  logic [TAB_W-1:0]    tab_left_q, tab_left_d;

  settle_t g1, g2, cr_s, lf_s;
  logic    tab_busy, accept, tab_final;

  assign tab_busy   = (tab_left_q != '0);
  assign in_ready_o = !tab_busy && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tab_final  = (tab_left_q == TAB_W'(1));

  always_comb begin
    g1   = settle({1'b0, col_q} + (COL_W+1)'(GLYPH_COLUMNS), row_q,
                  cfg_i.screen_width, cfg_i.screen_height);
    g2   = settle({1'b0, g1.col}, g1.row, cfg_i.screen_width, cfg_i.screen_height);
    cr_s = settle('0, row_q, cfg_i.screen_width, cfg_i.screen_height);
    lf_s = settle('0, row_q + ROWPOS_W'(GLYPH_ROWS),
                  cfg_i.screen_width, cfg_i.screen_height);

    q_push_o   = 1'b0;
    q_cmd_o    = '0;
    col_d      = col_q;
    row_d      = row_q;
    tab_left_d = tab_left_q;

    q_cmd_o.cur_row = row_q;
    q_cmd_o.cur_col = col_q;
    q_cmd_o.code    = char_code_i;
    q_cmd_o.grow    = glyph_row_i;
    q_cmd_o.bits    = glyph_bits_i;

    if (tab_busy) begin
      if (!q_full_i) begin
        q_push_o      = 1'b1;
        q_cmd_o.kind  = CMD_GLYPH;
        q_cmd_o.code  = CHAR_SPACE;
        q_cmd_o.last  = tab_final;
        tab_left_d    = tab_left_q - TAB_W'(1);
        // The last space also carries the check repeated after the tab.
        if (tab_final) begin
          q_cmd_o.clear = g1.ovf || g2.ovf;
          col_d         = g2.col;
          row_d         = g2.row;
        end else begin
          q_cmd_o.clear = g1.ovf;
          col_d         = g1.col;
          row_d         = g1.row;
        end
      end
    end else if (accept) begin
      if (req_type_i == REQ_LOAD) begin
        q_cmd_o.kind = CMD_LOAD;
        q_push_o     = (32'(char_code_i) < GLYPH_COUNT) && (32'(glyph_row_i) < GLYPH_ROWS);
      end else begin
        q_push_o = 1'b1;
        unique case (char_code_i)
          CHAR_CR: begin
            q_cmd_o.kind  = CMD_EMPTY;
            q_cmd_o.clear = cr_s.ovf;
            q_cmd_o.last  = 1'b1;
            col_d         = cr_s.col;
            row_d         = cr_s.row;
          end
          CHAR_LF: begin
            q_cmd_o.kind  = CMD_EMPTY;
            q_cmd_o.clear = lf_s.ovf;
            q_cmd_o.last  = 1'b1;
            col_d         = lf_s.col;
            row_d         = lf_s.row;
          end
          CHAR_TAB: begin
            q_cmd_o.kind  = CMD_GLYPH;
            q_cmd_o.code  = CHAR_SPACE;
            q_cmd_o.clear = g1.ovf;
            q_cmd_o.last  = 1'b0;
            col_d         = g1.col;
            row_d         = g1.row;
            tab_left_d    = TAB_W'(TAB_SPACES - 1);
          end
          default: begin
            q_cmd_o.kind  = CMD_GLYPH;
            q_cmd_o.clear = g1.ovf;
            q_cmd_o.last  = 1'b1;
            col_d         = g1.col;
            row_d         = g1.row;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      tab_left_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      tab_left_q <= tab_left_d;
    end
  end

endmodule

FILE: sv/tcgw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_queue: command queue between front end and back end
// A small circular buffer of command words.
// ----------------------------------------------------------------------------
module tcgw_queue import tcgw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t            entries_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QP_W:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (QP_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QP_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QP_W'(1) : rd_ptr_q;
    count_d  = count_q + (QP_W+1)'(do_push) - (QP_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: sv/tcgw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_back: glyph row sequencer
// Executes queued commands: writes font rows, steps through the sixteen rows
// of a glyph reading the font store, and drives the output register.
// ----------------------------------------------------------------------------
module tcgw_back import tcgw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               ram_we_o,
  output logic [FONT_AW-1:0] ram_waddr_o,
  output logic [BITS_W-1:0]  ram_wdata_o,
  output logic               ram_re_o,
  output logic [FONT_AW-1:0] ram_raddr_o,
  input  logic [BITS_W-1:0]  ram_rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OFF_W-1:0]   row_offset_o,
  output logic [BITS_W-1:0]  row_mask_o,
  output logic [COLOR_W-1:0] pen_color_o,
  output logic               clear_after_o,
  output logic [COLOR_W-1:0] fill_color_o,
  output logic               last_o
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_ROWS = 1'b1;

  logic                state_q, state_d;
  logic [ROW_W-1:0]    r_q, r_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic                clear_q, clear_d, last_q, last_d, blank_q, blank_d;
  logic [2*DIM_W-1:0]  prod;

  // Slot that lines up with the font store's registered read data.
  logic                a_valid_q, a_load, a_move, a_free;
  logic [OFF_W-1:0]    a_off_q, a_off_n;
  logic                a_glyph_q, a_glyph_n, a_blank_q, a_blank_n;
  logic                a_clear_q, a_clear_n, a_last_q, a_last_n;
  logic                final_row;

  logic                out_valid_q;
  logic [OFF_W-1:0]    row_offset_q;
  logic [BITS_W-1:0]   row_mask_q;
  logic [COLOR_W-1:0]  pen_color_q, fill_color_q;
  logic                clear_after_q, last_out_q;

  assign prod      = cmd_i.cur_row * cfg_i.line_pitch;
  assign a_move    = a_valid_q && (!out_valid_q || out_ready_i);
  assign a_free    = !a_valid_q || a_move;
  assign final_row = (r_q == ROW_W'(GLYPH_ROWS - 1));

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    off_d       = off_q;
    code_d      = code_q;
    clear_d     = clear_q;
    last_d      = last_q;
    blank_d     = blank_q;
    cmd_pop_o   = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = FONT_AW'(cmd_i.code) * FONT_AW'(GLYPH_ROWS) + FONT_AW'(cmd_i.grow);
    ram_wdata_o = cmd_i.bits;
    ram_re_o    = 1'b0;
    ram_raddr_o = FONT_AW'(code_q) * FONT_AW'(GLYPH_ROWS) + FONT_AW'(r_q);
    a_load      = 1'b0;
    a_off_n     = off_q;
    a_glyph_n   = 1'b1;
    a_blank_n   = blank_q;
    a_clear_n   = clear_q && final_row;
    a_last_n    = last_q && final_row;

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_LOAD: begin
              cmd_pop_o = 1'b1;
              ram_we_o  = 1'b1;
            end
            CMD_EMPTY: begin
              if (a_free) begin
                cmd_pop_o = 1'b1;
                a_load    = 1'b1;
                a_off_n   = '0;
                a_glyph_n = 1'b0;
                a_blank_n = 1'b1;
                a_clear_n = cmd_i.clear;
                a_last_n  = cmd_i.last;
              end
            end
            CMD_GLYPH: begin
              cmd_pop_o = 1'b1;
              state_d   = B_ROWS;
              r_d       = '0;
              off_d     = prod[OFF_W-1:0] + OFF_W'(cmd_i.cur_col);
              code_d    = cmd_i.code;
              clear_d   = cmd_i.clear;
              last_d    = cmd_i.last;
              blank_d   = !(32'(cmd_i.code) < GLYPH_COUNT);
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      B_ROWS: begin
        if (a_free) begin
          ram_re_o = 1'b1;
          a_load   = 1'b1;
          off_d    = off_q + OFF_W'(cfg_i.line_pitch);
          r_d      = r_q + ROW_W'(1);
          if (final_row) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    off_q   <= off_d;
    code_q  <= code_d;
    clear_q <= clear_d;
    last_q  <= last_d;
    blank_q <= blank_d;
    if (a_load) begin
      a_off_q   <= a_off_n;
      a_glyph_q <= a_glyph_n;
      a_blank_q <= a_blank_n;
      a_clear_q <= a_clear_n;
      a_last_q  <= a_last_n;
    end
    if (a_move) begin
      row_offset_q  <= a_off_q;
      row_mask_q    <= a_blank_q ? '0 : ram_rdata_i;
      pen_color_q   <= a_glyph_q ? cfg_i.text_color : '0;
      clear_after_q <= a_clear_q;
      fill_color_q  <= a_clear_q ? cfg_i.bg_color : '0;
      last_out_q    <= a_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_offset_o  = row_offset_q;
  assign row_mask_o    = row_mask_q;
  assign pen_color_o   = pen_color_q;
  assign clear_after_o = clear_after_q;
  assign fill_color_o  = fill_color_q;
  assign last_o        = last_out_q;

endmodule

FILE: sv/text_console_glyph_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_writer: 8x16 text console row writer
// Turns character codes into glyph row writes with a cursor, and loads
// glyph rows into the font store.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, req_type_i,         | input
//           | char_code_i, glyph_row_i, glyph_bits_i     |
//   out     | out_valid_o/out_ready_i, row_offset_o,     | output
//           | row_mask_o, pen_color_o, clear_after_o,    |
//           | fill_color_o, last_o                       |
//   cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i         | input
//
// A glyph load is a single font store write in the back end. A printable
// character first forms the base offset with the multiplier, then reads
// one row per cycle while the output is not stalled, paced by the single
// read port of the font store. A tab costs four characters, carriage return
// and newline one blank output word each. Reset clears the cursor and
// restores the configuration defaults; the font store holds no reset value
// and needs no clearing pass. A four-word queue lets the front end keep
// accepting words while the back end waits on the output.
// ----------------------------------------------------------------------------
module text_console_glyph_writer import tcgw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [CODE_W-1:0]    char_code_i,
  input  logic [GROW_W-1:0]    glyph_row_i,
  input  logic [BITS_W-1:0]    glyph_bits_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OFF_W-1:0]     row_offset_o,
  output logic [BITS_W-1:0]    row_mask_o,
  output logic [COLOR_W-1:0]   pen_color_o,
  output logic                 clear_after_o,
  output logic [COLOR_W-1:0]   fill_color_o,
  output logic                 last_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= DIM_W'(800);
      cfg_q.screen_height <= DIM_W'(600);
      cfg_q.line_pitch    <= DIM_W'(800);
      cfg_q.text_color    <= '1;
      cfg_q.bg_color      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata_i[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata_i[DIM_W-1:0];
        CFG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_wdata_i[DIM_W-1:0];
        CFG_TEXT_COLOR:    cfg_q.text_color    <= cfg_wdata_i[COLOR_W-1:0];
        CFG_BG_COLOR:      cfg_q.bg_color      <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic               q_push, q_full, q_pop, q_empty;
  cmd_t               q_in, q_head;
  logic               ram_we, ram_re;
  logic [FONT_AW-1:0] ram_waddr, ram_raddr;
  logic [BITS_W-1:0]  ram_wdata, ram_rdata;

  tcgw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .glyph_row_i  (glyph_row_i),
    .glyph_bits_i (glyph_bits_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in)
  );

  tcgw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_head),
    .empty_o (q_empty)
  );

  tcgw_ram #(
    .WIDTH (BITS_W),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcgw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (q_head),
    .cmd_valid_i   (!q_empty),
    .cmd_pop_o     (q_pop),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_offset_o  (row_offset_o),
    .row_mask_o    (row_mask_o),
    .pen_color_o   (pen_color_o),
    .clear_after_o (clear_after_o),
    .fill_color_o  (fill_color_o),
    .last_o        (last_o)
  );

endmodule

FILE: sv/tcgw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_checker: port-level checks of the text console glyph writer
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module tcgw_checker import tcgw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 req_type_i,
  input logic [CODE_W-1:0]    char_code_i,
  input logic [GROW_W-1:0]    glyph_row_i,
  input logic [BITS_W-1:0]    glyph_bits_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [OFF_W-1:0]     row_offset_o,
  input logic [BITS_W-1:0]    row_mask_o,
  input logic [COLOR_W-1:0]   pen_color_o,
  input logic                 clear_after_o,
  input logic [COLOR_W-1:0]   fill_color_o,
  input logic                 last_o
);

  // A waiting input word keeps its valid and its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(req_type_i) &&
      $stable(char_code_i) && $stable(glyph_row_i) && $stable(glyph_bits_i))
    else $error("input word changed while waiting");

  // A stalled output word keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_offset_o) &&
      $stable(row_mask_o) && $stable(pen_color_o) && $stable(clear_after_o) &&
      $stable(fill_color_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // The fill color is only shown with a screen fill.
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !clear_after_o |-> fill_color_o == '0)
    else $error("fill color without screen fill");

  // Reset leaves no output word pending.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // No output word is pending right after reset.
  a_no_early_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind text_console_glyph_writer tcgw_checker u_checker (.*);
